@@ sv/rfsl_pkg.sv @@
// Shared types and constants of the range frame speed limiter.
// No dependencies; used by the interfaces, the frame decoder and the top level.
package rfsl_pkg;

  typedef logic [7:0]         byte_t;
  typedef logic [3:0]         pos_t;
  typedef logic [6:0]         speed_t;
  typedef logic signed [25:0] dist_t;
  typedef logic signed [8:0]  digit_t;

  // Byte positions inside an 11-byte frame
  localparam pos_t PosFirst    = 4'd0;
  localparam pos_t PosMeter0   = 4'd3;
  localparam pos_t PosMeter1   = 4'd4;
  localparam pos_t PosMeter2   = 4'd5;
  localparam pos_t PosMilli0   = 4'd7;
  localparam pos_t PosMilli1   = 4'd8;
  localparam pos_t PosMilli2   = 4'd9;
  localparam pos_t PosCheck    = 4'd10;
  localparam pos_t FrameLen    = 4'd11;

  localparam byte_t AsciiZero  = 8'h30;
  localparam byte_t AsciiE     = 8'h45;
  localparam byte_t AsciiR     = 8'h52;

  localparam dist_t  NearMm     = 26'sd300;
  localparam dist_t  MidMm      = 26'sd1000;
  localparam speed_t SpeedReset = 7'd100;

  // Frame decoder status toward the top level
  typedef struct packed {
    logic  last;       // current byte is the checksum byte
    logic  good;       // checksum matches
    logic  err;        // meter digits read ERR
    dist_t range_mm;   // decoded distance
  } frame_res_t;

endpackage

@@ sv/rfsl_in_if.sv @@
// Input channel of the range frame speed limiter: one rangefinder byte per beat.
// Depends on rfsl_pkg.
interface rfsl_in_if;
  logic            valid;
  logic            ready;
  rfsl_pkg::byte_t rx_byte;
  logic            frame_begin;

  modport source (output valid, output rx_byte, output frame_begin, input ready);
  modport sink   (input valid, input rx_byte, input frame_begin, output ready);
endinterface

@@ sv/rfsl_out_if.sv @@
// Result channel of the range frame speed limiter: one frame verdict per beat.
// Depends on rfsl_pkg.
interface rfsl_out_if;
  logic             valid;
  logic             ready;
  logic             frame_good;
  logic             range_error;
  rfsl_pkg::dist_t  distance_mm;
  rfsl_pkg::speed_t speed_target;

  modport source (output valid, output frame_good, output range_error,
                  output distance_mm, output speed_target, input ready);
  modport sink   (input valid, input frame_good, input range_error,
                  input distance_mm, input speed_target, output ready);
endinterface

@@ sv/rfsl_frame.sv @@
// Frame tracker: byte position, running checksum, ERR flag and distance digits.
// Depends on rfsl_pkg.
module rfsl_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  rfsl_pkg::byte_t      rx_byte,
  input  logic                 frame_begin,
  output rfsl_pkg::frame_res_t res
);

  rfsl_pkg::pos_t  cnt_r, cnt_nxt;
  rfsl_pkg::byte_t sum_r, sum_nxt;
  rfsl_pkg::dist_t acc_r, acc_nxt;
  logic            err_r, err_nxt;

  rfsl_pkg::pos_t   pos;
  rfsl_pkg::digit_t digit;
  rfsl_pkg::dist_t  digit_ext;
  rfsl_pkg::dist_t  acc_x10;

  always_comb begin
    pos       = (frame_begin || cnt_r >= rfsl_pkg::FrameLen) ? rfsl_pkg::PosFirst : cnt_r;
    digit     = $signed({1'b0, rx_byte}) - $signed({1'b0, rfsl_pkg::AsciiZero});
    digit_ext = {{17{digit[8]}}, digit};
    // times ten as two shifts
    acc_x10   = (acc_r <<< 3) + (acc_r <<< 1);

    cnt_nxt = (pos == rfsl_pkg::PosCheck) ? rfsl_pkg::PosFirst : pos + 4'd1;
    sum_nxt = sum_r;
    acc_nxt = acc_r;
    err_nxt = err_r;

    if (pos == rfsl_pkg::PosFirst) begin
      sum_nxt = rx_byte;
    end else if (pos != rfsl_pkg::PosCheck) begin
      sum_nxt = sum_r + rx_byte;
    end

    // Horner over the six digits: meters first, millimeters last
    case (pos)
      rfsl_pkg::PosMeter0: begin
        acc_nxt = digit_ext;
        err_nxt = (rx_byte == rfsl_pkg::AsciiE);
      end
      rfsl_pkg::PosMeter1, rfsl_pkg::PosMeter2: begin
        acc_nxt = acc_x10 + digit_ext;
        err_nxt = err_r && (rx_byte == rfsl_pkg::AsciiR);
      end
      rfsl_pkg::PosMilli0, rfsl_pkg::PosMilli1, rfsl_pkg::PosMilli2: begin
        acc_nxt = acc_x10 + digit_ext;
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase

    res.last     = (pos == rfsl_pkg::PosCheck);
    res.good     = (rx_byte == (8'd0 - sum_r));
    res.err      = err_r;
    res.range_mm = acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= rfsl_pkg::PosFirst;
      sum_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      acc_r <= acc_nxt;
      err_r <= err_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rfsl_pkg::PosCheck)
    else $error("frame position out of range");
`endif

endmodule

@@ sv/range_frame_speed_limiter.sv @@
// Range frame speed limiter top level, built on rfsl_frame and the channel interfaces.
// Depends on rfsl_pkg, rfsl_in_if, rfsl_out_if and rfsl_frame.
//
// Takes one rangefinder byte per cycle. A byte goes into an input register and is
// decoded in the following cycle; the result of a frame is loaded into the output
// register at the edge where its checksum byte leaves the input register, so the
// checksum beat passes the input register and then the output register. Throughput is
// one byte per cycle; only a checksum byte waits, and then only while the output
// register still holds an untaken result. max_speed (max_r) is to be written by the
// user via cfg_we/cfg_wdata only while no frame result is pending; not enforced here.
module range_frame_speed_limiter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  rfsl_pkg::speed_t cfg_wdata,
  rfsl_in_if.sink          in_ch,
  rfsl_out_if.source       out_ch
);

  // input register
  logic             s1_valid_r;
  rfsl_pkg::byte_t  s1_byte_r;
  logic             s1_begin_r;

  // result register
  logic             out_valid_r;
  logic             out_good_r;
  logic             out_err_r;
  rfsl_pkg::dist_t  out_dist_r;
  rfsl_pkg::speed_t out_speed_r;

  rfsl_pkg::speed_t max_r;
  rfsl_pkg::speed_t target_r;

  rfsl_pkg::frame_res_t fr;
  logic             out_free;
  logic             s1_go;
  logic             step;
  logic             done;
  logic             err_q;
  rfsl_pkg::dist_t  dist_q;
  rfsl_pkg::speed_t speed_new;
  rfsl_pkg::speed_t speed_show;

  rfsl_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .rx_byte     (s1_byte_r),
    .frame_begin (s1_begin_r),
    .res         (fr)
  );

  always_comb begin
    out_free    = !out_valid_r || out_ch.ready;
    s1_go       = !fr.last || out_free;
    step        = s1_valid_r && s1_go;
    done        = step && fr.last;
    in_ch.ready = !s1_valid_r || s1_go;

    err_q  = fr.good && fr.err;
    dist_q = (fr.good && !fr.err) ? fr.range_mm : '0;

    if (dist_q <= rfsl_pkg::NearMm) begin
      speed_new = '0;
    end else if (dist_q <= rfsl_pkg::MidMm) begin
      speed_new = max_r >> 1;
    end else begin
      speed_new = max_r;
    end
    speed_show = fr.good ? speed_new : target_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_r       <= rfsl_pkg::SpeedReset;
      target_r    <= rfsl_pkg::SpeedReset;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (done && fr.good) begin
        target_r <= speed_new;
      end
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r  <= in_ch.rx_byte;
      s1_begin_r <= in_ch.frame_begin;
    end
    if (done) begin
      out_good_r  <= fr.good;
      out_err_r   <= err_q;
      out_dist_r  <= dist_q;
      out_speed_r <= speed_show;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_good   = out_good_r;
  assign out_ch.range_error  = out_err_r;
  assign out_ch.distance_mm  = out_dist_r;
  assign out_ch.speed_target = out_speed_r;

`ifndef SYNTHESIS
  a_hold_check_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && fr.last && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("checksum beat taken while result register is full");

  a_err_needs_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_good_r || (!out_err_r && out_dist_r == '0)))
    else $error("bad frame result carries range data");

  a_bad_keeps_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !fr.good) |=> (target_r == $past(target_r)))
    else $error("bad frame changed the target speed");

  a_result_speed: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (out_speed_r == target_r))
    else $error("result speed differs from kept target");
`endif

endmodule
